// ===== src/plist_pkg.sv =====
`default_nettype none

package plist_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_W        = 16;
    localparam int PAYLOAD_W    = 32;
    localparam int OP_W         = 4;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 3;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int WORD_W       = KEY_W + PAYLOAD_W;

    localparam int IN_BITS      = OP_W + POS_W + KEY_W + PAYLOAD_W;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = STATUS_W + KEY_W + PAYLOAD_W + CNT_W;
    localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_GET       = 4'd0,
        OP_SET       = 4'd1,
        OP_INS_FRONT = 4'd2,
        OP_INS_BACK  = 4'd3,
        OP_INS_AT    = 4'd4,
        OP_REM_FRONT = 4'd5,
        OP_REM_BACK  = 4'd6,
        OP_REM_AT    = 4'd7,
        OP_SEARCH    = 4'd8,
        OP_CLEAR     = 4'd9
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_BADPOS   = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_SEARCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [POS_W-1:0]     position;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [KEY_W-1:0]     found_key;
        logic [PAYLOAD_W-1:0] found_payload;
        logic [CNT_W-1:0]     count;
    } res_t;

endpackage

`default_nettype wire

// ===== src/positional_list_engine.sv =====
// Positional list engine: an ordered list of up to DEPTH (16) key/payload
// entries, addressed by one-based position, held in a single-port-read,
// single-port-write RAM.
// Input channel s_*: one command per transaction (get, set, inserts,
// removes, search, clear). Output channel m_*: exactly one result per
// command: status, the key and payload read, removed or found, and the
// entry count after the command.
// Set, clear, inserts at the back and error results go from idle straight
// to the result state; get passes through a read state first; commands
// that move or scan entries (insert ahead of, or remove, an entry; search)
// pass through a shift or search state. A command holds the sequencer
// until its result moves into the output register, so a new command is
// not taken before the last one is through. Shifts and searches are paced
// by the RAM: one entry read, and in a shift one written, per cycle.
// Commands are handled one at a time; s_tready is high while the sequencer
// is idle. A finished result waits in the output register, so the next
// command is accepted while m_tready is low; that command completes but is
// held in the sequencer until the output register frees up.
// Reset empties the list and the output register; no clearing pass is run,
// since entries beyond the count are never read.
`default_nettype none

module positional_list_engine
    import plist_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // op [3:0], position [8:4], key [24:9], payload [56:25], zeros above
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status [2:0], found_key [18:3], found_payload [50:19], count [55:51]
    output logic      [OUT_DATA_W-1:0] m_tdata
);

    cmd_t                  cmd;
    res_t                  res;
    logic                  res_valid, res_ack;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg;

    assign cmd.op       = s_tdata[OP_W-1:0];
    assign cmd.position = s_tdata[OP_W +: POS_W];
    assign cmd.key      = s_tdata[OP_W + POS_W +: KEY_W];
    assign cmd.payload  = s_tdata[OP_W + POS_W + KEY_W +: PAYLOAD_W];

    plist_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd       (cmd),
        .cmd_ready (s_tready),
        .res_valid (res_valid),
        .res       (res),
        .res_ack   (res_ack)
    );

    assign res_ack = res_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ack)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
            out_data_reg <= {res.count, res.found_payload, res.found_key, res.status};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule

`default_nettype wire

// ===== src/plist_ram.sv =====
`default_nettype none

module plist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/plist_seq.sv =====
`default_nettype none

module plist_seq
    import plist_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_ready,
    output logic      res_valid,
    output res_t      res,
    input  wire logic res_ack
);

    state_t state_reg, state_next, start_state;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     rd_addr_reg;
    logic                 more_reg, more_next;
    logic                 rd_vld_reg;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [PAYLOAD_W-1:0] pay_reg, pay_next;
    logic [STATUS_W-1:0]  stat_reg, stat_next;
    logic [KEY_W-1:0]     rkey_reg, rkey_next;
    logic [PAYLOAD_W-1:0] rpay_reg, rpay_next;

    logic                 wr_en, rd_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0]    wr_data, rd_data;
    logic [KEY_W-1:0]     rd_key;
    logic [PAYLOAD_W-1:0] rd_pay;

    logic                 start, pos_ok, is_full, is_empty, hit;
    logic [IDX_W-1:0]     pos_idx, last_idx, cnt_idx;

    plist_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Memory words hold the payload above the key.
    assign rd_key   = rd_data[KEY_W-1:0];
    assign rd_pay   = rd_data[WORD_W-1:KEY_W];

    assign start    = cmd_valid && (state_reg == S_IDLE);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos_ok   = (cmd.position != '0) && (POS_W'(count_reg) >= cmd.position);
    assign pos_idx  = IDX_W'(cmd.position - POS_W'(1));
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign cnt_idx  = IDX_W'(count_reg);
    assign hit      = rd_vld_reg && (rd_key == key_reg);

    // Which state an accepted command enters.
    always_comb
    begin
        start_state = S_DONE;
        case (cmd.op)
            OP_GET:
            begin
                if (pos_ok)
                    start_state = S_READ;
            end
            OP_INS_FRONT:
            begin
                if (!is_full && !is_empty)
                    start_state = S_SHIFT_UP;
            end
            OP_INS_AT:
            begin
                if (pos_ok && !is_full)
                    start_state = S_SHIFT_UP;
            end
            OP_REM_FRONT, OP_REM_BACK:
            begin
                if (!is_empty)
                    start_state = S_SHIFT_DN;
            end
            OP_REM_AT:
            begin
                if (!is_empty && pos_ok)
                    start_state = S_SHIFT_DN;
            end
            OP_SEARCH:
            begin
                if (!is_empty)
                    start_state = S_SEARCH;
            end
            default:
            begin
                start_state = S_DONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = start_state;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_SHIFT_UP, S_SHIFT_DN:
            begin
                if (!rd_vld_reg && !more_reg)
                    state_next = S_DONE;
            end
            S_SEARCH:
            begin
                if (hit || (!rd_vld_reg && !more_reg))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ack)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        more_next  = more_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        stat_next  = stat_reg;
        rkey_next  = rkey_reg;
        rpay_next  = rpay_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = {pay_reg, key_reg};
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next  = cmd.key;
                    pay_next  = cmd.payload;
                    stat_next = STAT_OK;
                    rkey_next = '0;
                    rpay_next = '0;
                    more_next = 1'b1;
                    case (cmd.op)
                        OP_GET:
                        begin
                            if (!pos_ok)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = pos_idx;
                            end
                        end
                        OP_SET:
                        begin
                            if (!pos_ok)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = pos_idx;
                                wr_data = {cmd.payload, cmd.key};
                            end
                        end
                        OP_INS_FRONT:
                        begin
                            if (is_full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else if (is_empty)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = {cmd.payload, cmd.key};
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ptr_next = last_idx;
                                idx_next = '0;
                            end
                        end
                        OP_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = cnt_idx;
                                wr_data    = {cmd.payload, cmd.key};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INS_AT:
                        begin
                            if (!pos_ok)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else if (is_full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                ptr_next = last_idx;
                                idx_next = pos_idx;
                            end
                        end
                        OP_REM_FRONT:
                        begin
                            if (is_empty)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ptr_next = '0;
                                idx_next = '0;
                            end
                        end
                        OP_REM_BACK:
                        begin
                            if (is_empty)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ptr_next = last_idx;
                                idx_next = last_idx;
                            end
                        end
                        OP_REM_AT:
                        begin
                            if (is_empty)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                ptr_next = pos_idx;
                                idx_next = pos_idx;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                stat_next = STAT_NOTFOUND;
                                ptr_next  = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rkey_next = rd_key;
                rpay_next = rd_pay;
            end
            S_SHIFT_UP:
            begin
                // Walk from the back toward the insert point; each word read
                // is written one place further back on the following cycle.
                rd_en = more_reg;
                if (more_reg)
                begin
                    ptr_next  = ptr_reg - IDX_W'(1);
                    more_next = (ptr_reg != idx_reg);
                end
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_addr_reg + IDX_W'(1);
                    wr_data = rd_data;
                end
                else if (!more_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg;
                    wr_data    = {pay_reg, key_reg};
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_SHIFT_DN:
            begin
                // The first word read is the removed entry; the rest move
                // one place toward the front.
                rd_en = more_reg;
                if (more_reg)
                begin
                    ptr_next  = ptr_reg + IDX_W'(1);
                    more_next = (ptr_reg != last_idx);
                end
                if (rd_vld_reg)
                begin
                    if (rd_addr_reg == idx_reg)
                    begin
                        rkey_next = rd_key;
                        rpay_next = rd_pay;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_addr_reg - IDX_W'(1);
                        wr_data = rd_data;
                    end
                end
                else if (!more_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_SEARCH:
            begin
                rd_en = more_reg && !hit;
                if (more_reg)
                begin
                    ptr_next  = ptr_reg + IDX_W'(1);
                    more_next = (ptr_reg != last_idx);
                end
                if (hit)
                begin
                    stat_next = STAT_OK;
                    rkey_next = rd_key;
                    rpay_next = rd_pay;
                end
            end
            S_DONE:
            begin
                more_next = 1'b0;
            end
            default:
            begin
                more_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            more_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            more_reg   <= more_next;
            rd_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        rd_addr_reg <= rd_addr;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        stat_reg    <= stat_next;
        rkey_reg    <= rkey_next;
        rpay_reg    <= rpay_next;
    end

    assign cmd_ready         = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_DONE);
    assign res.status        = stat_reg;
    assign res.found_key     = rkey_reg;
    assign res.found_payload = rpay_reg;
    assign res.count         = count_reg;

endmodule

`default_nettype wire

// ===== src/plist_checker.sv =====
`default_nettype none

module plist_checker
    import plist_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic [CNT_W-1:0]    cnt;
    logic [OP_W-1:0]     in_op;

    assign st    = m_tdata[STATUS_W-1:0];
    assign cnt   = m_tdata[STATUS_W + KEY_W + PAYLOAD_W +: CNT_W];
    assign in_op = s_tdata[OP_W-1:0];

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one command is in work at a time.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while another is in work");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt <= CNT_W'(DEPTH))
        else $error("count above capacity");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == STAT_FULL) |-> cnt == CNT_W'(DEPTH))
        else $error("full status with room left");

    // A clear taken while the output side is free leaves an empty list behind it.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (in_op == OP_CLEAR) && (!m_tvalid || m_tready)
        |-> ##2 m_tvalid && cnt == '0)
        else $error("clear did not empty the list");

endmodule

bind positional_list_engine plist_checker u_plist_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top
    import plist_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATUS_LSB  = 0;
    localparam int KEY_LSB     = STATUS_LSB + STATUS_W;
    localparam int PAYLOAD_LSB = KEY_LSB + KEY_W;
    localparam int COUNT_LSB   = PAYLOAD_LSB + PAYLOAD_W;
    localparam int LONG_HOLD   = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the list, updated as each command transaction is accepted.
    logic [KEY_W-1:0]     list_key [DEPTH];
    logic [PAYLOAD_W-1:0] list_pay [DEPTH];
    int                   list_len = 0;

    res_t expected_q [$];
    int   errors = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_left = 0;

    positional_list_engine DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic void insert_entry(input int idx, input logic [KEY_W-1:0] k,
                                         input logic [PAYLOAD_W-1:0] p);
        int i;
        for (i = list_len; i > idx; i--)
        begin
            list_key[i] = list_key[i-1];
            list_pay[i] = list_pay[i-1];
        end
        list_key[idx] = k;
        list_pay[idx] = p;
        list_len++;
    endfunction

    function automatic void remove_entry(input int idx, inout res_t r);
        int i;
        r.found_key     = list_key[idx];
        r.found_payload = list_pay[idx];
        for (i = idx; i < list_len - 1; i++)
        begin
            list_key[i] = list_key[i+1];
            list_pay[i] = list_pay[i+1];
        end
        list_len--;
    endfunction

    function automatic res_t apply_list_op(input cmd_t c);
        res_t r;
        int   idx;
        bit   pos_ok;
        r = '0;
        pos_ok = (c.position >= 1) && (c.position <= list_len);
        case (c.op)
            OP_GET:
                if (!pos_ok)
                    r.status = STAT_BADPOS;
                else
                begin
                    r.found_key     = list_key[c.position - 1];
                    r.found_payload = list_pay[c.position - 1];
                end
            OP_SET:
                if (!pos_ok)
                    r.status = STAT_BADPOS;
                else
                begin
                    list_key[c.position - 1] = c.key;
                    list_pay[c.position - 1] = c.payload;
                end
            OP_INS_FRONT:
                if (list_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                    insert_entry(0, c.key, c.payload);
            OP_INS_BACK:
                if (list_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                    insert_entry(list_len, c.key, c.payload);
            OP_INS_AT:
                // The position is checked ahead of the full condition.
                if (!pos_ok)
                    r.status = STAT_BADPOS;
                else if (list_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                    insert_entry(c.position - 1, c.key, c.payload);
            OP_REM_FRONT:
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else
                    remove_entry(0, r);
            OP_REM_BACK:
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else
                    remove_entry(list_len - 1, r);
            OP_REM_AT:
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else if (!pos_ok)
                    r.status = STAT_BADPOS;
                else
                    remove_entry(c.position - 1, r);
            OP_SEARCH:
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.status = STAT_NOTFOUND;
                    for (idx = 0; idx < list_len; idx++)
                    begin
                        if (list_key[idx] == c.key)
                        begin
                            r.status        = STAT_OK;
                            r.found_key     = list_key[idx];
                            r.found_payload = list_pay[idx];
                            break;
                        end
                    end
                end
            OP_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        r.count = CNT_W'(list_len);
        return r;
    endfunction

    function automatic cmd_t random_cmd(input int grow_pct);
        cmd_t c;
        int   pick;
        pick = $urandom_range(99);
        // Small keys make duplicates and search hits common.
        c.key     = ($urandom_range(1) == 1) ? KEY_W'($urandom_range(7)) : KEY_W'($urandom);
        c.payload = $urandom;
        case ($urandom_range(9))
            0:       c.position = ($urandom_range(1) == 1) ? POS_W'(0) : POS_W'(list_len + 1);
            1:       c.position = POS_W'($urandom_range(31));
            default: c.position = POS_W'($urandom_range(list_len > 0 ? list_len : 1, 1));
        endcase
        if (pick < 3)
            c.op = OP_W'($urandom_range(15, 10));
        else if (pick < 5)
            c.op = OP_CLEAR;
        else if (pick < 5 + grow_pct)
        begin
            case ($urandom_range(2))
                0:       c.op = OP_INS_FRONT;
                1:       c.op = OP_INS_BACK;
                default: c.op = OP_INS_AT;
            endcase
        end
        else
        begin
            case ($urandom_range(5))
                0:       c.op = OP_GET;
                1:       c.op = OP_SET;
                2:       c.op = OP_REM_FRONT;
                3:       c.op = OP_REM_BACK;
                4:       c.op = OP_REM_AT;
                default: c.op = OP_SEARCH;
            endcase
            if (c.op == OP_SEARCH && list_len > 0 && $urandom_range(9) < 6)
                c.key = list_key[$urandom_range(list_len - 1)];
        end
        return c;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [KEY_W-1:0] key, input logic [PAYLOAD_W-1:0] pay);
        cmd_t c;
        c.op       = op;
        c.position = pos;
        c.key      = key;
        c.payload  = pay;
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({c.payload, c.key, c.position, c.op});
        do @(posedge clk); while (!s_tready);
        expected_q.push_back(apply_list_op(c));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        res_t want;
        if (expected_q.size() == 0)
        begin
            $error("result transaction with no command pending: %0h", word);
            errors++;
        end
        else
        begin
            want = expected_q.pop_front();
            if (word[STATUS_LSB +: STATUS_W] !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status,
                       word[STATUS_LSB +: STATUS_W]);
                errors++;
            end
            if (word[KEY_LSB +: KEY_W] !== want.found_key)
            begin
                $error("found_key: expected %0h, got %0h", want.found_key,
                       word[KEY_LSB +: KEY_W]);
                errors++;
            end
            if (word[PAYLOAD_LSB +: PAYLOAD_W] !== want.found_payload)
            begin
                $error("found_payload: expected %0h, got %0h", want.found_payload,
                       word[PAYLOAD_LSB +: PAYLOAD_W]);
                errors++;
            end
            if (word[COUNT_LSB +: CNT_W] !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count,
                       word[COUNT_LSB +: CNT_W]);
                errors++;
            end
        end
    endtask

    // Result side: checks each accepted transaction and drives m_tready.
    always @(posedge clk)
    begin
        if (rst_n && m_tready && m_tvalid === 1'b1)
            check_result(m_tdata);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_cmd(OP_SEARCH, 5'd0, 16'h0000, 32'h0);
        send_cmd(OP_REM_FRONT, 5'd0, 16'h0000, 32'h0);
        send_cmd(OP_REM_BACK, 5'd0, 16'h0000, 32'h0);
        // Remove at reports the empty list even with a bad position.
        send_cmd(OP_REM_AT, 5'd0, 16'h0000, 32'h0);
        send_cmd(OP_GET, 5'd1, 16'h0000, 32'h0);
        send_cmd(OP_SET, 5'd1, 16'h0001, 32'h1);
        send_cmd(OP_INS_AT, 5'd1, 16'h0002, 32'h2);
        send_cmd(OP_INS_BACK, 5'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(OP_INS_FRONT, 5'd31, 16'h0000, 32'h0);
        send_cmd(OP_INS_AT, 5'd2, 16'h1234, 32'hA5A5_A5A5);
        send_cmd(OP_GET, 5'd0, 16'h0000, 32'h0);
        send_cmd(OP_GET, 5'd4, 16'h0000, 32'h0);
        send_cmd(OP_GET, 5'd31, 16'h0000, 32'h0);
        send_cmd(OP_GET, 5'd3, 16'h0000, 32'h0);
        send_cmd(OP_SET, 5'd1, 16'h1234, 32'h5A5A_5A5A);
        // Two entries now share a key; the one nearer the front must win.
        send_cmd(OP_SEARCH, 5'd0, 16'h1234, 32'h0);
        send_cmd(OP_SEARCH, 5'd0, 16'h7777, 32'h0);
        send_cmd(4'hF, 5'd1, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(4'hA, 5'd0, 16'h0000, 32'h0);
        send_cmd(OP_REM_AT, 5'd4, 16'h0000, 32'h0);
        send_cmd(OP_REM_AT, 5'd2, 16'h0000, 32'h0);
        send_cmd(OP_REM_BACK, 5'd0, 16'h0000, 32'h0);
        send_cmd(OP_REM_FRONT, 5'd0, 16'h0000, 32'h0);
        send_cmd(OP_INS_BACK, 5'd0, 16'h8001, 32'h8000_0001);
        send_cmd(OP_CLEAR, 5'd16, 16'h0000, 32'h0);
    endtask

    task automatic test_full_list();
        int k;
        for (k = 0; k < DEPTH; k++)
            send_cmd(OP_INS_BACK, POS_W'($urandom), KEY_W'($urandom), $urandom);
        send_cmd(OP_INS_FRONT, 5'd0, 16'h0101, 32'h1);
        send_cmd(OP_INS_BACK, 5'd0, 16'h0202, 32'h2);
        send_cmd(OP_INS_AT, 5'd16, 16'h0303, 32'h3);
        send_cmd(OP_INS_AT, 5'd17, 16'h0404, 32'h4);
        send_cmd(OP_INS_AT, 5'd0, 16'h0505, 32'h5);
        send_cmd(OP_SET, 5'd16, 16'hBEEF, 32'hCAFE_F00D);
        send_cmd(OP_GET, 5'd16, 16'h0000, 32'h0);
        send_cmd(OP_SEARCH, 5'd0, 16'hBEEF, 32'h0);
        send_cmd(OP_REM_AT, 5'd17, 16'h0000, 32'h0);
        send_cmd(OP_REM_AT, 5'd16, 16'h0000, 32'h0);
        send_cmd(OP_REM_AT, 5'd1, 16'h0000, 32'h0);
        send_cmd(OP_CLEAR, 5'd0, 16'h0000, 32'h0);
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        cmd_t c;
        int   k;
        int   grow;
        idle_pct  = idle;
        stall_pct = stall;
        grow      = 25;
        for (k = 0; k < n; k++)
        begin
            // Change the insert share now and then so the list swings between empty and full.
            if (k % 40 == 0)
            begin
                case ($urandom_range(3))
                    0:       grow = 15;
                    1:       grow = 25;
                    2:       grow = 45;
                    default: grow = 70;
                endcase
            end
            c = random_cmd(grow);
            send_cmd(c.op, c.position, c.key, c.payload);
        end
    endtask

    task automatic test_backpressure();
        cmd_t c;
        int   k;
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = LONG_HOLD;
        for (k = 0; k < 32; k++)
        begin
            c = random_cmd(50);
            send_cmd(c.op, c.position, c.key, c.payload);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_list();
        test_random(215, 0, 0);
        test_backpressure();
        test_random(215, 75, 0);
        test_random(215, 0, 75);
        test_random(215, 18, 18);
        wait_drained();
        repeat (DEPTH + 8) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
